/* rtl/dead_time_comp_hysteresis_macros.svh */
// Assertion helpers for the checker file.
`ifndef DEAD_TIME_COMP_HYSTERESIS_MACROS_SVH
`define DEAD_TIME_COMP_HYSTERESIS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DTC_ASSERT_IMPL(label, clk, rst, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("dtc assertion failed");

// Next-cycle implication, disabled during reset.
`define DTC_ASSERT_NEXT(label, clk, rst, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("dtc assertion failed");

`endif

/* rtl/dtc_pkg.sv */
`timescale 1ns / 1ps
package dtc_pkg;

  localparam int DUTY_MAX  = 16384;
  localparam int STATE_EXT = 10;
  localparam int FILT_W    = 26;
  // Quotient bits of the drop-term division (33-bit rounded dividend).
  localparam int DIV_STEPS = 33;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIODE_GAIN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_RES = 8'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_HOLD
  } ctrl_state_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] duty;
  } lane_result_t;

endpackage

/* rtl/dtc_divider.sv */
`timescale 1ns / 1ps
module dtc_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [dtc_pkg::DIV_STEPS-1:0]    dividend,
  input  logic [15:0]                      divisor,
  output logic                             done,
  output logic [dtc_pkg::DIV_STEPS-1:0]    quotient
);

  localparam int CNT_W = $clog2(dtc_pkg::DIV_STEPS);

  logic [15:0]      rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [16:0]      trial;
  logic [16:0]      diff;
  logic             fits;

  // Restoring division, one quotient bit per cycle. The dividend is shifted
  // out of the top of the quotient register as quotient bits enter below.
  always_comb begin
    trial = {rem, quotient[dtc_pkg::DIV_STEPS-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? diff[15:0] : trial[15:0];
        quotient <= {quotient[dtc_pkg::DIV_STEPS-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(dtc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/dtc_lane.sv */
`timescale 1ns / 1ps
module dtc_lane #(
  parameter int   FILTER_SHIFT = 10,
  parameter logic FLAG_INIT    = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [15:0]    cur,
  input  logic signed [15:0]    duty,
  input  logic [14:0]           ud,
  input  logic [14:0]           band,
  input  logic [15:0]           sr,
  input  logic [16:0]           t_term,
  output dtc_pkg::lane_result_t res
);

  localparam int FW  = dtc_pkg::FILT_W;
  localparam int SW  = 35;

  logic signed [FW-1:0] filt;
  logic                 flag;
  logic                 flag_used;
  logic [31:0]          mag;
  logic                 neg;
  logic                 div_go;

  logic signed [FW-1:0] target;
  logic signed [FW:0]   diff;
  logic signed [FW:0]   step;
  logic                 rising;
  logic                 falling;
  logic signed [16:0]   cur_ext;
  logic signed [16:0]   band_pos;
  logic signed [16:0]   band_neg;
  logic [15:0]          abs_cur;
  logic [dtc_pkg::DIV_STEPS-1:0] dividend;
  logic                 div_done;
  logic [dtc_pkg::DIV_STEPS-1:0] quo;
  logic signed [SW-1:0] q_term;
  logic signed [SW-1:0] t_signed;
  logic signed [SW-1:0] sum;
  logic signed [15:0]   clamped;

  always_comb begin
    target   = {cur, {dtc_pkg::STATE_EXT{1'b0}}};
    diff     = {target[FW-1], target} - {filt[FW-1], filt};
    step     = diff >>> FILTER_SHIFT;
    rising   = !step[FW] && (step != '0);
    falling  = step[FW];
    cur_ext  = {cur[15], cur};
    band_pos = $signed({2'b00, band});
    band_neg = -band_pos;
    abs_cur  = cur[15] ? 16'(-cur) : cur;
    // Rounded to nearest: (2*|R*I| + Ud) / (2*Ud).
    dividend = {mag, 1'b0} + {18'b0, ud};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt   <= '0;
      flag   <= FLAG_INIT;
      div_go <= 1'b0;
    end else begin
      div_go <= start;
      if (start) begin
        filt      <= filt + step[FW-1:0];
        flag_used <= flag;
        mag       <= sr * abs_cur;
        neg       <= cur[15];
        if (!flag) begin
          if (cur_ext >= band_neg && rising) begin
            flag <= 1'b1;
          end
        end else begin
          if (cur_ext <= band_pos && falling) begin
            flag <= 1'b0;
          end
        end
      end
    end
  end

  dtc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (dividend),
    .divisor  ({ud, 1'b0}),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    if (ud == '0) begin
      q_term = '0;
    end else if (neg) begin
      q_term = -$signed({2'b00, quo});
    end else begin
      q_term = $signed({2'b00, quo});
    end
    t_signed = flag_used ? -$signed({18'b0, t_term}) : $signed({18'b0, t_term});
    sum      = $signed({{(SW-16){duty[15]}}, duty}) + t_signed + q_term;
    if (sum > SW'(dtc_pkg::DUTY_MAX)) begin
      clamped = 16'(dtc_pkg::DUTY_MAX);
    end else if (sum < -SW'(dtc_pkg::DUTY_MAX)) begin
      clamped = -16'(dtc_pkg::DUTY_MAX);
    end else begin
      clamped = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.done <= 1'b0;
    end else begin
      res.done <= div_done;
      if (div_done) begin
        res.duty <= clamped;
      end
    end
  end

endmodule

/* rtl/dead_time_comp_hysteresis.sv */
`timescale 1ns / 1ps
// Dead-time compensation for a three-phase inverter, one transaction per
// PWM period. The input channel (in_valid / in_stall) carries the three
// phase currents, the three duty references and the DC bus voltage; the
// output channel (out_valid / out_stall) returns the three compensated,
// clamped duties and the zero-bus fault flag. Registers are written over
// cfg_valid / cfg_ready / cfg_index / cfg_data; the user must write them
// only while the block is idle, which the block does not enforce. cfg_ready
// is always high and unknown indexes are ignored. Each phase has its own
// lane with a current filter, a polarity flag with hysteresis and a
// one-bit-per-cycle divider for the resistive drop term. An accepted input
// passes the start register, each lane's 33-step divider and its result
// register; a new input is taken the cycle after the result is loaded.
// Reset clears the filters, sets the polarity flags to U 0, V 1, W 0,
// zeroes the configuration registers and empties the output. If the
// receiver stalls, the result waits in the output register and in_stall
// stays high once the next result is ready and cannot be loaded.
module dead_time_comp_hysteresis #(
  parameter int FILTER_SHIFT = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             current_u,
  input  logic signed [15:0]             current_v,
  input  logic signed [15:0]             current_w,
  input  logic signed [15:0]             duty_a_in,
  input  logic signed [15:0]             duty_b_in,
  input  logic signed [15:0]             duty_c_in,
  input  logic [14:0]                    bus_voltage,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [15:0]             duty_a_out,
  output logic signed [15:0]             duty_b_out,
  output logic signed [15:0]             duty_c_out,
  output logic                           zero_bus_fault,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);

  dtc_pkg::ctrl_state_t state, state_next;

  logic [13:0]        dead_time_term;
  logic [15:0]        diode_drop_gain;
  logic [14:0]        current_band;
  logic [15:0]        switch_resistance;

  logic signed [15:0] cur_u, cur_v, cur_w;
  logic signed [15:0] duty_a, duty_b, duty_c;
  logic [14:0]        ud;
  logic               start;
  logic [30:0]        t_prod;
  logic [16:0]        t_term;
  logic [31:0]        t_round;

  dtc_pkg::lane_result_t res_a, res_b, res_c;
  logic               lanes_done;
  logic               out_free;
  logic               accept;
  logic               load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_time_term    <= '0;
      diode_drop_gain   <= '0;
      current_band      <= '0;
      switch_resistance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtc_pkg::REG_DEAD_TIME:  dead_time_term    <= cfg_data[13:0];
        dtc_pkg::REG_DIODE_GAIN: diode_drop_gain   <= cfg_data;
        dtc_pkg::REG_BAND:       current_band      <= cfg_data[14:0];
        dtc_pkg::REG_SWITCH_RES: switch_resistance <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign lanes_done = res_a.done & res_b.done & res_c.done;
  assign out_free   = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      dtc_pkg::ST_IDLE: begin
        if (in_valid) state_next = dtc_pkg::ST_BUSY;
      end
      dtc_pkg::ST_BUSY: begin
        if (lanes_done) state_next = out_free ? dtc_pkg::ST_IDLE : dtc_pkg::ST_HOLD;
      end
      dtc_pkg::ST_HOLD: begin
        if (out_free) state_next = dtc_pkg::ST_IDLE;
      end
      default: state_next = dtc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != dtc_pkg::ST_IDLE);
    accept   = in_valid && !in_stall;
    load     = out_free && ((state == dtc_pkg::ST_BUSY && lanes_done) ||
                            state == dtc_pkg::ST_HOLD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtc_pkg::ST_IDLE;
      start <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_u  <= current_u;
      cur_v  <= current_v;
      cur_w  <= current_w;
      duty_a <= duty_a_in;
      duty_b <= duty_b_in;
      duty_c <= duty_c_in;
      ud     <= bus_voltage;
    end
  end

  // The dead-time term is registered in t_prod and then t_term once the
  // inputs are latched, well before any lane finishes its division.
  assign t_round = {1'b0, t_prod} + 32'd32768;

  always_ff @(posedge clk) begin
    t_prod <= diode_drop_gain * ud;
    t_term <= {3'b000, dead_time_term} + {1'b0, t_round[31:16]};
  end

  dtc_lane #(.FILTER_SHIFT(FILTER_SHIFT), .FLAG_INIT(1'b0)) u_lane_u (
    .clk (clk), .rst (rst), .start (start), .cur (cur_u), .duty (duty_a),
    .ud (ud), .band (current_band), .sr (switch_resistance), .t_term (t_term),
    .res (res_a)
  );

  dtc_lane #(.FILTER_SHIFT(FILTER_SHIFT), .FLAG_INIT(1'b1)) u_lane_v (
    .clk (clk), .rst (rst), .start (start), .cur (cur_v), .duty (duty_b),
    .ud (ud), .band (current_band), .sr (switch_resistance), .t_term (t_term),
    .res (res_b)
  );

  dtc_lane #(.FILTER_SHIFT(FILTER_SHIFT), .FLAG_INIT(1'b0)) u_lane_w (
    .clk (clk), .rst (rst), .start (start), .cur (cur_w), .duty (duty_c),
    .ud (ud), .band (current_band), .sr (switch_resistance), .t_term (t_term),
    .res (res_c)
  );

  // Merge the lane results and the fault flag into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      duty_a_out     <= res_a.duty;
      duty_b_out     <= res_b.duty;
      duty_c_out     <= res_c.duty;
      zero_bus_fault <= (ud == '0);
    end
  end

endmodule

/* rtl/dtc_checker.sv */
`timescale 1ns / 1ps
`include "dead_time_comp_hysteresis_macros.svh"
module dtc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [15:0]             duty_a_out,
  input logic signed [15:0]             duty_b_out,
  input logic signed [15:0]             duty_c_out,
  input logic                           zero_bus_fault
);

  logic out_in_range;

  assign out_in_range =
    (duty_a_out >= -16'sd16384) && (duty_a_out <= 16'sd16384) &&
    (duty_b_out >= -16'sd16384) && (duty_b_out <= 16'sd16384) &&
    (duty_c_out >= -16'sd16384) && (duty_c_out <= 16'sd16384);

  // A stalled result holds.
  `DTC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(duty_a_out) && $stable(duty_b_out) && $stable(duty_c_out) && $stable(zero_bus_fault))

  // Every delivered duty is within plus or minus DUTY_MAX (16384).
  `DTC_ASSERT_IMPL(a_out_range, clk, rst, out_valid, out_in_range)

  // After taking a transaction the block is busy until its result is loaded.
  `DTC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // When a fresh result appears, the block has freed its input side.
  `DTC_ASSERT_IMPL(a_rise_frees_input, clk, rst, $rose(out_valid), !in_stall)

endmodule

bind dead_time_comp_hysteresis dtc_checker u_dtc_checker (.*);
